// ===== rtl/bfc_pkg.sv =====
// Shared types, constants and the CRC byte function of the beacon frame classifier.
package bfc_pkg;

  localparam int unsigned IDX_W               = 8;
  localparam int unsigned DEF_MAX_FRAME_BYTES = 127;
  localparam int unsigned MIN_FRAME_BYTES     = 13;

  localparam logic [15:0] BROADCAST_ADDR = 16'hFFFF;
  localparam logic [15:0] CRC_TAPS       = 16'h8408;

  localparam logic [IDX_W-1:0] OFS_TYPE    = 8'd1;
  localparam logic [IDX_W-1:0] OFS_DEST_LO = 8'd5;
  localparam logic [IDX_W-1:0] OFS_DEST_HI = 8'd6;
  localparam logic [IDX_W-1:0] OFS_SLOT    = 8'd11;
  localparam logic [IDX_W-1:0] OFS_TIME_B0 = 8'd14;
  localparam logic [IDX_W-1:0] OFS_TIME_B1 = 8'd15;
  localparam logic [IDX_W-1:0] OFS_TIME_B2 = 8'd16;
  localparam logic [IDX_W-1:0] OFS_TIME_B3 = 8'd17;

  localparam logic [2:0] V_SHORT         = 3'd0;
  localparam logic [2:0] V_CRC_ERROR     = 3'd1;
  localparam logic [2:0] V_NOT_ADDRESSED = 3'd2;
  localparam logic [2:0] V_JOIN_REQUEST  = 3'd3;
  localparam logic [2:0] V_SEND_MESSAGE  = 3'd4;
  localparam logic [2:0] V_SLOT_ASSIGNED = 3'd5;
  localparam logic [2:0] V_NO_ACTION     = 3'd6;

  localparam int unsigned CFG_W      = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_W-1:0] CFG_OWN_ADDRESS = 2'd0;
  localparam logic [CFG_W-1:0] CFG_BEACON_TYPE = 2'd1;
  localparam logic [CFG_W-1:0] CFG_ASSOC_TYPE  = 2'd2;

  localparam logic [15:0] RST_OWN_ADDRESS = 16'h0000;
  localparam logic [7:0]  RST_BEACON_TYPE = 8'h01;
  localparam logic [7:0]  RST_ASSOC_TYPE  = 8'h02;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_end;
    logic       message_waiting;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]         verdict;
    logic signed [31:0] send_time_ms;
    logic [7:0]         slot_number;
    logic               is_assigned;
    logic [31:0]        frames_counted;
    logic [31:0]        crc_errors;
  } out_beat_t;

  typedef struct packed {
    logic        crc_ok;
    logic        long_enough;
    logic [15:0] dest;
    logic [7:0]  type_code;
    logic [7:0]  slot;
    logic [31:0] beacon_time;
  } frame_info_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int k = 0; k < 8; k++) begin
      fb = b[k] ^ c[0];
      c  = c >> 1;
      if (fb) begin
        c = c ^ CRC_TAPS;
      end
    end
    return c;
  endfunction

endpackage

// ===== rtl/bfc_frame_track.sv =====
// Per-frame byte tracking: CRC, byte position and captured header fields.
module bfc_frame_track
  import bfc_pkg::*;
#(
  parameter int unsigned MAX_FRAME_BYTES = DEF_MAX_FRAME_BYTES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        adv,
  input  in_beat_t    beat,
  output frame_info_t info
);

  logic [15:0]      crc_r, crc_nxt, crc_base;
  logic [IDX_W-1:0] idx_r, idx_nxt, idx_inc;
  logic [15:0]      dest_r, dest_nxt;
  logic [7:0]       type_r, type_nxt;
  logic [7:0]       slot_r, slot_nxt;
  logic [31:0]      btime_r, btime_nxt;
  logic             first;

  always_comb begin
    first     = (idx_r == '0);
    crc_base  = first ? 16'h0000 : crc_r;
    dest_nxt  = first ? 16'h0000 : dest_r;
    type_nxt  = first ? 8'h00 : type_r;
    slot_nxt  = first ? 8'h00 : slot_r;
    btime_nxt = first ? 32'h0 : btime_r;

    if (idx_r == OFS_TYPE) begin
      type_nxt = beat.data_byte;
    end
    if (idx_r == OFS_DEST_LO) begin
      dest_nxt[7:0] = beat.data_byte;
    end
    if (idx_r == OFS_DEST_HI) begin
      dest_nxt[15:8] = beat.data_byte;
    end
    if (idx_r == OFS_SLOT) begin
      slot_nxt = beat.data_byte;
    end
    if (idx_r == OFS_TIME_B0) begin
      btime_nxt[7:0] = beat.data_byte;
    end
    if (idx_r == OFS_TIME_B1) begin
      btime_nxt[15:8] = beat.data_byte;
    end
    if (idx_r == OFS_TIME_B2) begin
      btime_nxt[23:16] = beat.data_byte;
    end
    if (idx_r == OFS_TIME_B3) begin
      btime_nxt[31:24] = beat.data_byte;
    end

    crc_nxt = crc_byte(crc_base, beat.data_byte);
    idx_inc = (idx_r < IDX_W'(MAX_FRAME_BYTES)) ? idx_r + 1'b1 : idx_r;
    idx_nxt = beat.frame_end ? '0 : idx_inc;

    info.crc_ok      = (crc_nxt == 16'h0000);
    info.long_enough = (idx_inc >= IDX_W'(MIN_FRAME_BYTES));
    info.dest        = dest_nxt;
    info.type_code   = type_nxt;
    info.slot        = slot_nxt;
    info.beacon_time = btime_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r   <= '0;
      idx_r   <= '0;
      dest_r  <= '0;
      type_r  <= '0;
      slot_r  <= '0;
      btime_r <= '0;
    end else if (adv) begin
      crc_r   <= crc_nxt;
      idx_r   <= idx_nxt;
      dest_r  <= dest_nxt;
      type_r  <= type_nxt;
      slot_r  <= slot_nxt;
      btime_r <= btime_nxt;
    end
  end

endmodule

// ===== rtl/bfc_verdict.sv =====
// Frame verdict, slot assignment and frame and error counters.
module bfc_verdict
  import bfc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        fire,
  input  frame_info_t info,
  input  logic        message_waiting,
  input  logic [15:0] own_address,
  input  logic [7:0]  beacon_type_code,
  input  logic [7:0]  assoc_type_code,
  output out_beat_t   result
);

  logic        assigned_r, assigned_nxt;
  logic [7:0]  slot_r, slot_nxt;
  logic [31:0] frames_r, frames_nxt;
  logic [31:0] errors_r, errors_nxt;
  logic [2:0]  verdict;
  logic [31:0] send_time;

  always_comb begin
    assigned_nxt = assigned_r;
    slot_nxt     = slot_r;
    frames_nxt   = frames_r;
    errors_nxt   = errors_r;
    send_time    = 32'h0;
    verdict      = V_NO_ACTION;

    priority if (!info.long_enough) begin
      verdict = V_SHORT;
    end else begin
      frames_nxt = frames_r + 32'd1;
      priority if (!info.crc_ok) begin
        errors_nxt = errors_r + 32'd1;
        verdict    = V_CRC_ERROR;
      end else if (info.dest != BROADCAST_ADDR && info.dest != own_address) begin
        verdict = V_NOT_ADDRESSED;
      end else if (info.type_code == beacon_type_code) begin
        priority if (!assigned_r) begin
          verdict = V_JOIN_REQUEST;
        end else if (message_waiting) begin
          verdict   = V_SEND_MESSAGE;
          send_time = info.beacon_time + {24'h0, slot_r};
        end else begin
          verdict = V_NO_ACTION;
        end
      end else if (info.type_code == assoc_type_code) begin
        if (!assigned_r) begin
          slot_nxt     = info.slot;
          assigned_nxt = 1'b1;
          verdict      = V_SLOT_ASSIGNED;
        end else begin
          verdict = V_NO_ACTION;
        end
      end else begin
        verdict = V_NO_ACTION;
      end
    end

    result.verdict        = verdict;
    result.send_time_ms   = $signed(send_time);
    result.slot_number    = slot_nxt;
    result.is_assigned    = assigned_nxt;
    result.frames_counted = frames_nxt;
    result.crc_errors     = errors_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      assigned_r <= 1'b0;
      slot_r     <= '0;
      frames_r   <= '0;
      errors_r   <= '0;
    end else if (fire) begin
      assigned_r <= assigned_nxt;
      slot_r     <= slot_nxt;
      frames_r   <= frames_nxt;
      errors_r   <= errors_nxt;
    end
  end

endmodule

// ===== rtl/tdma_beacon_frame_classifier.sv =====
// Beacon frame classifier top level: input register, frame logic and result register.
// Takes one received frame byte per beat and returns one verdict beat for each byte
// marked as frame end, at one byte per clock cycle while the input side is not stalled.
// A verdict is computed from the last byte in the input register and captured in the
// result register; the rate is set by the byte-wide CRC-16 update and the decision
// logic between the two registers. The input side stalls only while a finished verdict
// waits on out_ready and a further frame-end byte is queued behind it. Configuration
// writes take effect on the next cycle and are meant for when no frame is in progress.
module tdma_beacon_frame_classifier
  import bfc_pkg::*;
#(
  parameter int unsigned MAX_FRAME_BYTES = DEF_MAX_FRAME_BYTES
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_beat_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_beat_t             out_data
);

  logic [15:0] own_addr_r;
  logic [7:0]  beacon_type_r;
  logic [7:0]  assoc_type_r;

  logic        s1_valid_r, s1_valid_nxt;
  in_beat_t    s1_data_r;
  logic        s1_adv, fire, out_free, in_acc;
  logic        out_valid_r, out_valid_nxt;
  out_beat_t   out_data_r;

  frame_info_t info;
  out_beat_t   result;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_addr_r    <= RST_OWN_ADDRESS;
      beacon_type_r <= RST_BEACON_TYPE;
      assoc_type_r  <= RST_ASSOC_TYPE;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_OWN_ADDRESS: own_addr_r    <= cfg_wdata[15:0];
        CFG_BEACON_TYPE: beacon_type_r <= cfg_wdata[7:0];
        CFG_ASSOC_TYPE:  assoc_type_r  <= cfg_wdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    out_free      = !out_valid_r || out_ready;
    s1_adv        = s1_valid_r && (!s1_data_r.frame_end || out_free);
    fire          = s1_adv && s1_data_r.frame_end;
    in_ready      = !s1_valid_r || s1_adv;
    in_acc        = in_valid && in_ready;
    s1_valid_nxt  = in_acc ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_r);
    out_valid_nxt = fire ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_data_r <= in_data;
    end
    if (fire) begin
      out_data_r <= result;
    end
  end

  bfc_frame_track #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_track (
    .clk  (clk),
    .rst_n(rst_n),
    .adv  (s1_adv),
    .beat (s1_data_r),
    .info (info)
  );

  bfc_verdict u_verdict (
    .clk             (clk),
    .rst_n           (rst_n),
    .fire            (fire),
    .info            (info),
    .message_waiting (s1_data_r.message_waiting),
    .own_address     (own_addr_r),
    .beacon_type_code(beacon_type_r),
    .assoc_type_code (assoc_type_r),
    .result          (result)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/bfc_checker.sv =====
// Port-level checker of the beacon frame classifier and its bind.
module bfc_checker
  import bfc_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_beat_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without a stalled result");

  a_send_assigned: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.verdict == V_SEND_MESSAGE |-> out_data.is_assigned)
    else $error("send time given to an unassigned node");

  a_time_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.verdict != V_SEND_MESSAGE |-> out_data.send_time_ms == 32'sd0)
    else $error("send time nonzero without a send verdict");

endmodule

bind tdma_beacon_frame_classifier bfc_checker u_bfc_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_ready (in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);
